// File: rtl/tlnfrm_pkg.sv
// Package for the telnet line framer: payload types, telnet codes,
// result kinds and the prompt texts used by the login-mode line closer.
// No dependencies.
`default_nettype none

package tlnfrm_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] kind_type;
   typedef logic [1:0] csr_index_type;
   typedef logic [3:0] line_pos_type;
   typedef logic [2:0] prompt_mask_type;

   typedef struct packed {
      kind_type kind;
      byte_type out_byte;
   } result_type;

   // Result kinds
   localparam kind_type KIND_DATA     = 2'd0;
   localparam kind_type KIND_LINE_END = 2'd1;
   localparam kind_type KIND_LOGOUT   = 2'd2;

   // Configuration register indexes
   localparam csr_index_type CSR_LOW_CHAR   = 2'd0;
   localparam csr_index_type CSR_HIGH_CHAR  = 2'd1;
   localparam csr_index_type CSR_LOGIN_MODE = 2'd2;

   // Configuration reset values
   localparam byte_type LOW_CHAR_RESET  = 8'd32;
   localparam byte_type HIGH_CHAR_RESET = 8'd126;

   // Telnet codes
   localparam byte_type TN_IAC  = 8'd255;
   localparam byte_type TN_DONT = 8'd254;
   localparam byte_type TN_DO   = 8'd253;
   localparam byte_type TN_WONT = 8'd252;
   localparam byte_type TN_WILL = 8'd251;
   localparam byte_type TN_IP   = 8'd244;
   localparam byte_type CH_LF   = 8'd10;

   // One past carriage return: floor of the printable range
   localparam byte_type MIN_LOW_CHAR = 8'd14;
   localparam line_pos_type LINE_SAT = 4'd11;

   // Prompts, one bit of the match mask each
   localparam int NUM_PROMPTS = 3;
   localparam logic [1:0] PROMPT_LOGIN = 2'd0;
   localparam logic [1:0] PROMPT_PASS  = 2'd1;
   localparam logic [1:0] PROMPT_ROOT  = 2'd2;

   localparam int LOGIN_LEN = 7;
   localparam int PASS_LEN  = 10;
   localparam int ROOT_LEN  = 3;

   localparam logic [8*LOGIN_LEN-1:0] LOGIN_TEXT = "Login: ";
   localparam logic [8*PASS_LEN-1:0]  PASS_TEXT  = "Password: ";
   localparam logic [8*ROOT_LEN-1:0]  ROOT_TEXT  = "#> ";

   // Length of a prompt
   function automatic line_pos_type prompt_len(input logic [1:0] idx);
      line_pos_type len;
      len = '0;
      case (idx)
         PROMPT_LOGIN: len = line_pos_type'(LOGIN_LEN);
         PROMPT_PASS:  len = line_pos_type'(PASS_LEN);
         PROMPT_ROOT:  len = line_pos_type'(ROOT_LEN);
         default:      len = '0;
      endcase
      return len;
   endfunction

   // Character of a prompt at a line position; zero past its end
   function automatic byte_type prompt_char(input logic [1:0] idx, input line_pos_type pos);
      byte_type ch;
      ch = '0;
      case (idx)
         PROMPT_LOGIN:
            if (pos < line_pos_type'(LOGIN_LEN))
               ch = LOGIN_TEXT[8*(LOGIN_LEN-1-int'(pos)) +: 8];
         PROMPT_PASS:
            if (pos < line_pos_type'(PASS_LEN))
               ch = PASS_TEXT[8*(PASS_LEN-1-int'(pos)) +: 8];
         PROMPT_ROOT:
            if (pos < line_pos_type'(ROOT_LEN))
               ch = ROOT_TEXT[8*(ROOT_LEN-1-int'(pos)) +: 8];
         default: ch = '0;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// File: rtl/tlnfrm_if.sv
// Handshake channel interfaces of the telnet line framer: received bytes,
// framed results and configuration writes. Depends on tlnfrm_pkg.
`default_nettype none

interface tlnfrm_req_if;
   logic                 valid;
   logic                 ready;
   tlnfrm_pkg::byte_type data_byte;
   logic                 chunk_end;
   modport source (output valid, output data_byte, output chunk_end, input ready);
   modport sink   (input valid, input data_byte, input chunk_end, output ready);
endinterface

interface tlnfrm_rsp_if;
   logic                 valid;
   logic                 ready;
   tlnfrm_pkg::kind_type kind;
   tlnfrm_pkg::byte_type out_byte;
   modport source (output valid, output kind, output out_byte, input ready);
   modport sink   (input valid, input kind, input out_byte, output ready);
endinterface

interface tlnfrm_csr_if;
   logic                      valid;
   logic                      ready;
   tlnfrm_pkg::csr_index_type index;
   tlnfrm_pkg::byte_type      data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/telnet_strip_line_framer.sv
// Top level of the telnet line framer: command filter, prompt tracker and
// a four-entry result queue. Depends on tlnfrm_pkg and tlnfrm_if.
`default_nettype none

// Strips telnet IAC commands from a received byte stream and frames lines.
// One byte is taken per clock while req_ready is high: the filter and prompt
// tracker update in the cycle an item is accepted, and its zero, one or two
// results enter a four-entry result queue that drains one result per cycle
// while rsp_ready is high. req_ready stays high while the queue has room for
// two results, so with rsp_ready held high the block sustains one byte per
// cycle; only a chunk end that closes a prompt line adds a second result, and
// a long run of those slows intake, as the queue has a single read port.
// After IAC IP the block reports a logout error and then swallows every byte
// until reset. Configuration writes are always accepted.
module telnet_strip_line_framer (
   input  wire          clock,
   input  wire          reset,
   tlnfrm_req_if.sink   req_ch,
   tlnfrm_rsp_if.source rsp_ch,
   tlnfrm_csr_if.sink   csr_ch
);
   import tlnfrm_pkg::*;

   // Command filter state codes
   localparam logic [1:0] CMD_DATA  = 2'd0;
   localparam logic [1:0] CMD_IAC   = 2'd1;
   localparam logic [1:0] CMD_SKIP  = 2'd2;

   localparam int QDEPTH = 4;

   // Configuration
   byte_type low_char_ff, high_char_ff;
   logic     login_mode_ff;

   // Framer state
   logic [1:0]      cmd_state_ff, cmd_state_in;
   line_pos_type    line_pos_ff, line_pos_in;
   prompt_mask_type match_ff, match_in;
   logic            kept_ff, kept_in;
   logic            halted_ff, halted_in;

   // Result queue
   result_type  queue_ff [QDEPTH];
   logic [1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [2:0]  count_ff, count_in;

   logic        req_fire, rsp_fire;
   logic [1:0]  push_count;
   result_type  push0, push1;
   byte_type    lo_eff, c;
   logic        prompt_hit;

   assign req_fire     = req_ch.valid & req_ch.ready;
   assign rsp_fire     = rsp_ch.valid & rsp_ch.ready;
   assign req_ch.ready = (count_ff <= 3'(QDEPTH - 2));
   assign csr_ch.ready = 1'b1;
   assign c            = req_ch.data_byte;
   assign lo_eff       = (low_char_ff < MIN_LOW_CHAR) ? MIN_LOW_CHAR : low_char_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_char_ff   <= LOW_CHAR_RESET;
         high_char_ff  <= HIGH_CHAR_RESET;
         login_mode_ff <= 1'b1;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_LOW_CHAR:   low_char_ff   <= csr_ch.data;
            CSR_HIGH_CHAR:  high_char_ff  <= csr_ch.data;
            CSR_LOGIN_MODE: login_mode_ff <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // Per-byte filter, prompt tracking and result selection
   always_comb begin
      logic stop_now;
      cmd_state_in = cmd_state_ff;
      line_pos_in  = line_pos_ff;
      match_in     = match_ff;
      kept_in      = kept_ff;
      halted_in    = halted_ff;
      push_count   = 2'd0;
      push0        = '0;
      push1        = '0;
      prompt_hit   = 1'b0;
      stop_now     = 1'b0;

      if (req_fire && !halted_ff) begin
         case (cmd_state_ff)
            CMD_DATA: begin
               if (c == TN_IAC) begin
                  cmd_state_in = CMD_IAC;
               end else if (c == CH_LF) begin
                  kept_in     = 1'b1;
                  push0       = '{kind: KIND_LINE_END, out_byte: '0};
                  push_count  = 2'd1;
                  line_pos_in = '0;
                  match_in    = '1;
               end else if (c >= lo_eff && c <= high_char_ff) begin
                  kept_in    = 1'b1;
                  push0      = '{kind: KIND_DATA, out_byte: c};
                  push_count = 2'd1;
                  for (int i = 0; i < NUM_PROMPTS; i++) begin
                     if (line_pos_ff >= prompt_len(2'(i)) ||
                         prompt_char(2'(i), line_pos_ff) != c)
                        match_in[i] = 1'b0;
                  end
                  if (line_pos_ff < LINE_SAT)
                     line_pos_in = line_pos_ff + 4'd1;
               end
            end
            CMD_IAC: begin
               if (c == TN_IP) begin
                  halted_in  = 1'b1;
                  push0      = '{kind: KIND_LOGOUT, out_byte: '0};
                  push_count = 2'd1;
                  stop_now   = 1'b1;
               end else if (c == TN_DO || c == TN_WILL || c == TN_WONT || c == TN_DONT) begin
                  cmd_state_in = CMD_SKIP;
               end else begin
                  cmd_state_in = CMD_DATA;
               end
            end
            default: cmd_state_in = CMD_DATA;
         endcase

         // Prompt closer at a chunk end, on the updated open line
         if (req_ch.chunk_end && !stop_now) begin
            for (int i = 0; i < NUM_PROMPTS; i++) begin
               if (match_in[i] && line_pos_in == prompt_len(2'(i)))
                  prompt_hit = 1'b1;
            end
            if (kept_in && login_mode_ff && prompt_hit) begin
               if (push_count == 2'd0) begin
                  push0 = '{kind: KIND_LINE_END, out_byte: '0};
               end else begin
                  push1 = '{kind: KIND_LINE_END, out_byte: '0};
               end
               push_count  = push_count + 2'd1;
               line_pos_in = '0;
               match_in    = '1;
            end
            kept_in = 1'b0;
         end
      end

      count_in = count_ff + 3'(push_count) - 3'(rsp_fire);
   end

   // Framer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_state_ff <= CMD_DATA;
         line_pos_ff  <= '0;
         match_ff     <= '1;
         kept_ff      <= 1'b0;
         halted_ff    <= 1'b0;
      end else begin
         cmd_state_ff <= cmd_state_in;
         line_pos_ff  <= line_pos_in;
         match_ff     <= match_in;
         kept_ff      <= kept_in;
         halted_ff    <= halted_in;
      end
   end

   // Result queue pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + push_count;
         rd_ptr_ff <= rd_ptr_ff + 2'(rsp_fire);
         count_ff  <= count_in;
      end
   end

   // Result queue storage
   always_ff @(posedge clock) begin
      if (push_count != 2'd0)
         queue_ff[wr_ptr_ff] <= push0;
      if (push_count == 2'd2)
         queue_ff[wr_ptr_ff + 2'd1] <= push1;
   end

   assign rsp_ch.valid    = (count_ff != 3'd0);
   assign rsp_ch.kind     = queue_ff[rd_ptr_ff].kind;
   assign rsp_ch.out_byte = queue_ff[rd_ptr_ff].out_byte;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(QDEPTH))
      else $error("result queue count beyond depth");

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt cleared without reset");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> push_count == 2'd0)
      else $error("result produced while halted");

   a_two_needs_login: assert property (@(posedge clock) disable iff (reset)
      push_count == 2'd2 |-> login_mode_ff && req_ch.chunk_end)
      else $error("second result without prompt close");

   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> count_ff <= 3'(QDEPTH))
      else $error("item accepted without queue room");
`endif

endmodule

`default_nettype wire

// File: test/telnet_strip_line_framer_tb.sv
// Self-checking testbench for telnet_strip_line_framer: random byte streams with
// telnet commands and login prompts, checked item by item against a predictor.
// Depends on tlnfrm_pkg, tlnfrm_if and the framer RTL.
`timescale 1ns / 100ps

module telnet_strip_line_framer_tb;
   import tlnfrm_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 150;

   // Telnet command filter phases
   typedef enum logic [1:0] {
      CMD_PLAIN       = 2'd0,
      CMD_AFTER_IAC   = 2'd1,
      CMD_SKIP_OPTION = 2'd2,
      CMD_UNUSED      = 2'd3
   } cmd_phase_type;

   // Predicts framer output and checks the results as they arrive
   class line_frame_scoreboard;
      byte_type      low_char;
      byte_type      high_char;
      logic          login_mode;
      cmd_phase_type cmd;
      int            line_len;
      bit [2:0]      still_matching;
      bit            kept_in_chunk;
      bit            halted;
      result_type    expected_results[$];
      string         prompts[3];
      int            errors;
      int            n_items;
      int            n_data;
      int            n_line_ends;
      int            n_prompt_closes;
      int            n_logouts;
      int            n_reg_writes;

      function new();
         prompts[0] = "Login: ";
         prompts[1] = "Password: ";
         prompts[2] = "#> ";
         low_char = LOW_CHAR_RESET;
         high_char = HIGH_CHAR_RESET;
         login_mode = 1'b1;
         cmd = CMD_PLAIN;
         kept_in_chunk = 1'b0;
         halted = 1'b0;
         clear_line();
         errors = 0;
         n_items = 0;
         n_data = 0;
         n_line_ends = 0;
         n_prompt_closes = 0;
         n_logouts = 0;
         n_reg_writes = 0;
      endfunction

      function void clear_line();
         line_len = 0;
         still_matching = 3'b111;
      endfunction

      function void write_reg(csr_index_type idx, byte_type val);
         n_reg_writes++;
         case (idx)
            CSR_LOW_CHAR:   low_char = val;
            CSR_HIGH_CHAR:  high_char = val;
            CSR_LOGIN_MODE: login_mode = val[0];
            default: ;
         endcase
      endfunction

      function void expect_result(kind_type k, byte_type b);
         result_type r;
         r.kind = k;
         r.out_byte = b;
         expected_results.push_back(r);
         case (k)
            KIND_DATA:     n_data++;
            KIND_LINE_END: n_line_ends++;
            default:       n_logouts++;
         endcase
      endfunction

      // Drop prompts that no longer match the open line, then grow it
      function void advance_prompts(byte_type c);
         for (int i = 0; i < 3; i++) begin
            if (line_len >= prompts[i].len() || byte_type'(prompts[i][line_len]) != c)
               still_matching[i] = 1'b0;
         end
         if (line_len < int'(LINE_SAT))
            line_len++;
      endfunction

      // One accepted input item
      function void note_byte(byte_type c, logic last);
         byte_type lo;
         bit closed;
         lo = (low_char < MIN_LOW_CHAR) ? MIN_LOW_CHAR : low_char;
         closed = 1'b0;
         n_items++;
         if (halted)
            return;
         case (cmd)
            CMD_PLAIN: begin
               if (c == TN_IAC) begin
                  cmd = CMD_AFTER_IAC;
               end else if (c == CH_LF) begin
                  kept_in_chunk = 1'b1;
                  expect_result(KIND_LINE_END, '0);
                  clear_line();
               end else if (c >= lo && c <= high_char) begin
                  kept_in_chunk = 1'b1;
                  expect_result(KIND_DATA, c);
                  advance_prompts(c);
               end
            end
            CMD_AFTER_IAC: begin
               if (c == TN_IP) begin
                  halted = 1'b1;
                  expect_result(KIND_LOGOUT, '0);
                  return;
               end else if (c == TN_DO || c == TN_WILL || c == TN_WONT || c == TN_DONT) begin
                  cmd = CMD_SKIP_OPTION;
               end else begin
                  cmd = CMD_PLAIN;
               end
            end
            // skip state and the unused code both drop one byte
            default: cmd = CMD_PLAIN;
         endcase
         // prompt close at chunk end
         if (last) begin
            if (kept_in_chunk && login_mode) begin
               for (int i = 0; i < 3; i++) begin
                  if (!closed && still_matching[i] && line_len == prompts[i].len()) begin
                     expect_result(KIND_LINE_END, '0);
                     n_prompt_closes++;
                     clear_line();
                     closed = 1'b1;
                  end
               end
            end
            kept_in_chunk = 1'b0;
         end
      endfunction

      function void check_result(kind_type k, byte_type b);
         result_type want;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got kind %0d byte %02h",
                     $time, k, b);
         end else begin
            want = expected_results.pop_front();
            if (want.kind != k) begin
               errors++;
               $display("%0t: kind mismatch, expected %0d, got %0d", $time, want.kind, k);
            end
            if (want.out_byte != b) begin
               errors++;
               $display("%0t: out_byte mismatch, expected %02h, got %02h",
                        $time, want.out_byte, b);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   bit   req_no_gaps = 1'b0;
   bit   rsp_no_gaps = 1'b0;
   bit   hold_off_req = 1'b0;
   int   items_sent = 0;
   line_frame_scoreboard sb;

   tlnfrm_req_if req_if();
   tlnfrm_rsp_if rsp_if();
   tlnfrm_csr_if csr_if();

   telnet_strip_line_framer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always #1 clock = ~clock;

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, sb.expected_results.size());
         $display("telnet_strip_line_framer test failed");
         $finish;
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result(rsp_if.kind, rsp_if.out_byte);
   end

   function automatic int idle_draw(bit no_gaps);
      if (no_gaps || $urandom_range(0, 1) == 0)
         return 0;
      return $urandom_range(1, 12);
   endfunction

   // Result receiver: random stalls plus an occasional long hold-off
   initial begin
      int wait_cycles;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         wait_cycles = idle_draw(rsp_no_gaps);
         if (wait_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   // Offer one byte and wait until it is taken
   task automatic send_item(byte_type c, logic last);
      int gap;
      gap = idle_draw(req_no_gaps);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= c;
      req_if.chunk_end <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_byte(c, last);
      items_sent++;
   endtask

   // Same, but never completes an interrupt command before the final phase
   task automatic send_safe(byte_type c, logic last);
      if (sb.cmd == CMD_AFTER_IAC && c == TN_IP)
         c = 8'd241;
      send_item(c, last);
   endtask

   task automatic send_text(string s, logic end_on_last);
      for (int k = 0; k < s.len(); k++)
         send_item(byte_type'(s[k]), end_on_last && k == s.len() - 1);
   endtask

   task automatic csr_put(csr_index_type idx, byte_type val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic write_regs(byte_type lo, byte_type hi, logic mode);
      csr_put(CSR_LOW_CHAR, lo);
      csr_put(CSR_HIGH_CHAR, hi);
      csr_put(CSR_LOGIN_MODE, {7'd0, mode});
      csr_if.valid <= 1'b0;
   endtask

   // Stop offering and let every expected result drain
   task automatic settle();
      req_if.valid <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly prompts, text lines and telnet negotiations; some raw noise
   task automatic random_phase(int count);
      int target;
      int sel;
      int p;
      int cut;
      int n;
      byte_type ch;
      string word;
      target = items_sent + count;
      while (items_sent < target) begin
         sel = $urandom_range(0, 9);
         if (sel <= 3) begin
            p = $urandom_range(0, 2);
            word = sb.prompts[p];
            if ($urandom_range(0, 9) < 7)
               send_safe(CH_LF, $urandom_range(0, 3) == 0);
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, word.len()) : word.len();
            for (int k = 0; k < cut; k++) begin
               ch = byte_type'(word[k]);
               if ($urandom_range(0, 11) == 0)
                  ch = byte_type'($urandom_range(0, 255));
               send_safe(ch, (k == cut - 1) ? ($urandom_range(0, 9) < 7)
                                            : ($urandom_range(0, 7) == 0));
            end
            // chunk ending on a dropped byte
            if ($urandom_range(0, 3) == 0)
               send_safe(byte_type'($urandom_range(0, 9)), 1'b1);
         end else if (sel == 4) begin
            n = $urandom_range(0, 14);
            for (int k = 0; k < n; k++)
               send_safe(byte_type'($urandom_range(32, 126)), $urandom_range(0, 7) == 0);
            send_safe(CH_LF, $urandom_range(0, 2) == 0);
         end else if (sel == 5) begin
            send_safe(TN_IAC, 1'b0);
            send_safe(byte_type'($urandom_range(251, 254)), $urandom_range(0, 5) == 0);
            send_safe(byte_type'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end else if (sel == 6) begin
            send_safe(TN_IAC, $urandom_range(0, 5) == 0);
            send_safe(byte_type'($urandom_range(236, 255)), $urandom_range(0, 3) == 0);
         end else begin
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++)
               send_safe(byte_type'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
         end
      end
   endtask

   // Stimulus
   initial begin
      sb = new();
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.chunk_end = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_LOW_CHAR;
      csr_if.data = '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // directed: prompt close, newline, filtered bytes, telnet commands
      send_text("Login: ", 1'b1);
      send_item(CH_LF, 1'b0);
      send_item(8'd0, 1'b0);
      send_item(8'd13, 1'b0);
      send_item(8'd127, 1'b0);
      send_item(TN_IAC, 1'b0);
      send_item(TN_WILL, 1'b0);
      send_item("x", 1'b0);
      send_item(TN_IAC, 1'b0);
      send_item(TN_WONT, 1'b0);
      send_item(TN_DONT, 1'b0);
      send_item(TN_IAC, 1'b0);
      send_item(TN_DO, 1'b0);
      send_item(TN_IAC, 1'b0);
      send_item(TN_IAC, 1'b0);
      send_item(TN_IAC, 1'b0);
      send_item("a", 1'b1);
      send_item(CH_LF, 1'b0);
      send_text("#> ", 1'b1);

      // defaults, gaps on both sides
      random_phase(300);
      settle();

      // widest range, no idling at all
      write_regs(8'd0, 8'd255, 1'b1);
      req_no_gaps = 1'b1;
      rsp_no_gaps = 1'b1;
      random_phase(300);
      settle();

      // only newlines pass
      write_regs(8'd255, 8'd255, 1'b1);
      req_no_gaps = 1'b0;
      rsp_no_gaps = 1'b0;
      random_phase(150);
      settle();

      // empty range, prompts off
      write_regs(8'd100, 8'd50, 1'b0);
      random_phase(150);
      settle();

      // floor below carriage return, prompts off, receiver always ready
      write_regs(8'd13, 8'd126, 1'b0);
      rsp_no_gaps = 1'b1;
      random_phase(300);
      settle();

      // back to defaults; receiver holds off while the sender keeps pushing
      write_regs(8'd32, 8'd126, 1'b1);
      req_no_gaps = 1'b1;
      rsp_no_gaps = 1'b0;
      hold_off_req = 1'b1;
      random_phase(200);
      hold_off_req = 1'b1;
      random_phase(200);
      settle();

      // interrupt: logout error, then everything is swallowed
      req_no_gaps = 1'b0;
      send_item("q", 1'b0);
      send_item(TN_IAC, 1'b0);
      send_item(TN_IP, 1'b0);
      send_item("b", 1'b0);
      send_item(CH_LF, 1'b1);
      send_item(TN_IAC, 1'b0);
      send_item(TN_IP, 1'b1);
      settle();

      $display("%0d bytes sent over %0d register writes; %0d data, %0d line ends",
               sb.n_items, sb.n_reg_writes, sb.n_data, sb.n_line_ends);
      $display("of those line ends %0d closed prompts; %0d logout errors; %0d errors",
               sb.n_prompt_closes, sb.n_logouts, sb.errors);
      if (sb.errors == 0)
         $display("telnet_strip_line_framer test passed");
      else
         $display("telnet_strip_line_framer test failed");
      $finish;
   end

endmodule
